// File: src/fse_pkg.sv
package fse_pkg;

  localparam logic [1:0] KIND_FMT  = 2'd0;
  localparam logic [1:0] KIND_STR  = 2'd1;
  localparam logic [1:0] KIND_NULL = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] NULL_LAST = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHAR   = 6'b000010,
    S_SIGN   = 6'b000100,
    S_DIGITS = 6'b001000,
    S_NULL   = 6'b010000,
    S_COUNT  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    CV_IDLE  = 3'b001,
    CV_SHIFT = 3'b010,
    CV_OUT   = 3'b100
  } conv_state_t;

  // one digit offered by the converter
  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
    logic       last;
  } dig_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] w;
    w = {4'h0, d};
    if (d < 4'd10) begin
      hex_char = CH_ZERO + w;
    end else begin
      hex_char = CH_LOWA + w - 8'd10;
    end
  endfunction

  function automatic logic [7:0] null_char(input logic [2:0] idx);
    case (idx)
      3'd0:    null_char = 8'h28;
      3'd1:    null_char = 8'h6e;
      3'd2:    null_char = 8'h75;
      3'd3:    null_char = 8'h6c;
      3'd4:    null_char = 8'h6c;
      3'd5:    null_char = 8'h29;
      default: null_char = 8'h00;
    endcase
  endfunction

endpackage

// File: src/fse_conv.sv
module fse_conv #(
  parameter int ARG_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 is_hex,
  input  logic [ARG_WIDTH-1:0] mag,
  input  logic                 take,
  output fse_pkg::dig_t        dig
);

  localparam int NDIG = (ARG_WIDTH * 30103) / 100000 + 1;
  localparam int DW   = NDIG * 4;
  localparam int CW   = $clog2(ARG_WIDTH + 1);
  localparam int LW   = $clog2(NDIG + 1);

  fse_pkg::conv_state_t state;
  logic [ARG_WIDTH-1:0] bits;
  logic [CW-1:0]        cnt;
  logic [DW-1:0]        digs;
  logic [DW-1:0]        adj;
  logic [LW-1:0]        left;
  logic                 seen;
  logic [3:0]           top;
  logic                 show;

  // add-3 correction per bcd digit before each shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (digs[4*i +: 4] >= 4'd5) ? digs[4*i +: 4] + 4'd3 : digs[4*i +: 4];
    end
  end

  assign top  = digs[DW-1 -: 4];
  assign show = seen || (top != 4'd0) || (left == LW'(1));

  assign dig.valid = (state == fse_pkg::CV_OUT) && show;
  assign dig.digit = top;
  assign dig.last  = (left == LW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fse_pkg::CV_IDLE;
    end else begin
      case (state)
        fse_pkg::CV_IDLE: begin
          if (start) begin
            bits <= mag;
            cnt  <= CW'(ARG_WIDTH);
            left <= LW'(NDIG);
            seen <= 1'b0;
            if (is_hex) begin
              digs  <= {{(DW-ARG_WIDTH){1'b0}}, mag};
              state <= fse_pkg::CV_OUT;
            end else begin
              digs  <= '0;
              state <= fse_pkg::CV_SHIFT;
            end
          end
        end
        fse_pkg::CV_SHIFT: begin
          digs <= {adj[DW-2:0], bits[ARG_WIDTH-1]};
          bits <= bits << 1;
          cnt  <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= fse_pkg::CV_OUT;
          end
        end
        fse_pkg::CV_OUT: begin
          // leading zeros are skipped one digit per cycle
          if (!show || take) begin
            digs <= digs << 4;
            left <= left - LW'(1);
            seen <= seen | show;
            if (left == LW'(1)) begin
              state <= fse_pkg::CV_IDLE;
            end
          end
        end
        default: state <= fse_pkg::CV_IDLE;
      endcase
    end
  end

endmodule

// File: src/format_string_engine.sv
// streaming printf-style formatter
// input channel (in_valid/in_ready) carries kind, char_byte and int_arg; each
// request yields zero or more characters on the output channel
// (out_valid/out_ready), one per transfer, with last set on the final one.
// a request is taken only while the sequencer is idle; it then works on that
// one request until its last result sits in the output register.
// plain characters, "%%" and string bytes: the request moves the sequencer to
// S_CHAR, which loads the result into the output register when it can accept.
// "(null)": six results, one per cycle unless the receiver stalls. a request
// with no result leaves the sequencer idle. %x: digit positions are walked in
// turn, leading zeros included; there are floor(ARG_WIDTH*log10(2))+1 positions.
// %d: bit-serial binary to bcd conversion over all ARG_WIDTH bits, then each
// digit position in turn, leading zeros included; a leading '-' overlaps
// the conversion.
// an end request emits a pending '%' and then the saturating character count,
// after which state, pending flag, string mode and count return to reset values.
// rst (synchronous) clears the sequencer, flags, counter and output valid.
// when the receiver stalls, the output register holds and the sequencer waits;
// a new request is still taken while a finished result waits to be taken.
module format_string_engine #(
  parameter int ARG_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [7:0]                  char_byte,
  input  logic signed [ARG_WIDTH-1:0] int_arg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_char,
  output logic                        is_count,
  output logic [31:0]                 char_count,
  output logic                        last
);

  fse_pkg::state_t state;
  logic            pending;
  logic            smode;
  logic [31:0]     total;
  logic [7:0]      ch;
  logic            end_after;
  logic [2:0]      nidx;

  logic                 accept;
  logic                 can_push;
  logic                 push;
  logic                 fire;
  logic [7:0]           pch;
  logic                 plast;
  logic                 pcount;
  logic                 conv_start;
  logic                 conv_hex;
  logic [ARG_WIDTH-1:0] arg_u;
  logic [ARG_WIDTH-1:0] conv_mag;
  fse_pkg::dig_t        dig;

  assign in_ready = (state == fse_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_push = !out_valid || out_ready;

  assign arg_u      = int_arg;
  assign conv_hex   = (char_byte == fse_pkg::CH_X);
  assign conv_start = accept && (kind == fse_pkg::KIND_FMT) && pending
                      && ((char_byte == fse_pkg::CH_D) || conv_hex);
  assign conv_mag   = (conv_hex || !arg_u[ARG_WIDTH-1]) ? arg_u : (~arg_u + ARG_WIDTH'(1));

  fse_conv #(.ARG_WIDTH(ARG_WIDTH)) u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .is_hex (conv_hex),
    .mag    (conv_mag),
    .take   (fire && (state == fse_pkg::S_DIGITS)),
    .dig    (dig)
  );

  always_comb begin
    push   = 1'b0;
    pch    = fse_pkg::CH_NUL;
    plast  = 1'b0;
    pcount = 1'b0;
    case (state)
      fse_pkg::S_CHAR: begin
        push  = 1'b1;
        pch   = ch;
        plast = !end_after;
      end
      fse_pkg::S_SIGN: begin
        push = 1'b1;
        pch  = fse_pkg::CH_MINUS;
      end
      fse_pkg::S_DIGITS: begin
        push  = dig.valid;
        pch   = fse_pkg::hex_char(dig.digit);
        plast = dig.last;
      end
      fse_pkg::S_NULL: begin
        push  = 1'b1;
        pch   = fse_pkg::null_char(nidx);
        plast = (nidx == fse_pkg::NULL_LAST);
      end
      fse_pkg::S_COUNT: begin
        push   = 1'b1;
        pcount = 1'b1;
        plast  = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  assign fire = push && can_push;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid  <= 1'b1;
      out_char   <= pch;
      is_count   <= pcount;
      char_count <= pcount ? total : 32'd0;
      last       <= plast;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fse_pkg::S_IDLE;
      pending   <= 1'b0;
      smode     <= 1'b0;
      total     <= 32'd0;
      end_after <= 1'b0;
    end else begin
      if (fire && !pcount && (total != 32'hffff_ffff)) begin
        total <= total + 32'd1;
      end
      case (state)
        fse_pkg::S_IDLE: begin
          if (accept) begin
            end_after <= (kind == fse_pkg::KIND_END) && pending;
            nidx      <= 3'd0;
            ch        <= (kind == fse_pkg::KIND_END) ? fse_pkg::CH_PCT : char_byte;
            case (kind)
              fse_pkg::KIND_FMT: begin
                smode <= pending && (char_byte == fse_pkg::CH_S);
                if (pending) begin
                  pending <= 1'b0;
                  if (char_byte == fse_pkg::CH_D) begin
                    state <= arg_u[ARG_WIDTH-1] ? fse_pkg::S_SIGN : fse_pkg::S_DIGITS;
                  end else if (conv_hex) begin
                    state <= fse_pkg::S_DIGITS;
                  end else if (char_byte == fse_pkg::CH_PCT) begin
                    state <= fse_pkg::S_CHAR;
                  end
                end else if (char_byte == fse_pkg::CH_PCT) begin
                  pending <= 1'b1;
                end else begin
                  state <= fse_pkg::S_CHAR;
                end
              end
              fse_pkg::KIND_STR: begin
                if (smode) begin
                  if (char_byte == fse_pkg::CH_NUL) begin
                    smode <= 1'b0;
                  end else begin
                    state <= fse_pkg::S_CHAR;
                  end
                end
              end
              fse_pkg::KIND_NULL: begin
                if (smode) begin
                  smode <= 1'b0;
                  state <= fse_pkg::S_NULL;
                end
              end
              fse_pkg::KIND_END: begin
                // a lone '%' goes out ahead of the count
                if (pending) begin
                  state <= fse_pkg::S_CHAR;
                end else begin
                  state <= fse_pkg::S_COUNT;
                end
              end
              default: state <= fse_pkg::S_IDLE;
            endcase
          end
        end
        fse_pkg::S_CHAR: begin
          if (fire) begin
            state <= end_after ? fse_pkg::S_COUNT : fse_pkg::S_IDLE;
          end
        end
        fse_pkg::S_SIGN: begin
          if (fire) begin
            state <= fse_pkg::S_DIGITS;
          end
        end
        fse_pkg::S_DIGITS: begin
          if (fire && dig.last) begin
            state <= fse_pkg::S_IDLE;
          end
        end
        fse_pkg::S_NULL: begin
          if (fire) begin
            nidx <= nidx + 3'd1;
            if (nidx == fse_pkg::NULL_LAST) begin
              state <= fse_pkg::S_IDLE;
            end
          end
        end
        fse_pkg::S_COUNT: begin
          if (fire) begin
            pending <= 1'b0;
            smode   <= 1'b0;
            total   <= 32'd0;
            state   <= fse_pkg::S_IDLE;
          end
        end
        default: state <= fse_pkg::S_IDLE;
      endcase
    end
  end

endmodule

// File: src/fse_checker.sv
module fse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_char,
  input logic        is_count,
  input logic [31:0] char_count,
  input logic        last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(is_count)
      && $stable(char_count) && $stable(last))
    else $error("stalled result changed");

  a_count_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_count |-> (out_char == 8'h00) && last)
    else $error("count result malformed");

  a_char_zero_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_count |-> (char_count == 32'd0))
    else $error("character result carries a count");

  // an end request always produces a result, so the engine is busy after it
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == fse_pkg::KIND_END) |=> !in_ready)
    else $error("end request left engine idle");

endmodule

bind format_string_engine fse_checker u_fse_checker (.*);
